// File: sv/ssf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssf_pkg;

  localparam int SEQ_LEN_DEF = 5;
  localparam int SEQ_REG_W   = 40;
  localparam int APB_DATA_W  = 64;
  localparam int APB_ADDR_W  = 4;

  // register index decode: paddr[3] selects the 8-byte slot
  localparam logic REG_STOP_SEQ = 1'b0;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_STOP = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CNT_KEEP  = 2'd0,
    CNT_INC   = 2'd1,
    CNT_CLEAR = 2'd2,
    CNT_ONE   = 2'd3
  } cnt_op_t;

  typedef struct packed {
    logic    capture;
    logic    set_finished;
    cnt_op_t cnt_op;
    logic    rel_clear;
    logic    rel_inc;
    logic    emit;
    logic    emit_prefix;
    kind_t   emit_kind;
    logic    emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic finished;
    logic cmd_end;
    logic cnt_zero;
    logic match_hit;
    logic cnt_top;
    logic first_hit;
    logic rel_at_end;
    logic out_free;
  } dp_status_t;

  // byte k of the stop sequence; bytes past the register read as zero
  function automatic logic [7:0] seq_byte(input logic [SEQ_REG_W-1:0] s,
                                          input logic [2:0] k);
    logic [63:0] ext;
    ext = {{(64 - SEQ_REG_W){1'b0}}, s};
    return ext[{k, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

// File: sv/ssf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ssf_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] in_byte;

  modport source (output valid, output command, output in_byte, input ready);
  modport sink   (input valid, input command, input in_byte, output ready);
endinterface

`default_nettype wire

// File: sv/ssf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ssf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_kind, output out_byte, output out_last,
                  input ready);
  modport sink   (input valid, input out_kind, input out_byte, input out_last,
                  output ready);
endinterface

`default_nettype wire

// File: sv/stop_sequence_stream_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel     Dir  Handshake     Payload
// upstream    in   valid/ready   command, in_byte
// downstream  out  valid/ready   out_kind, out_byte, out_last
// apb         in   psel/penable  paddr, pwdata -> stop_sequence (addr 0)
//
// One request at a time. A request is taken in IDLE, evaluated the next
// cycle, then its results leave one per cycle, while downstream accepts,
// through the output register. The single output register sets the pace;
// a stalled downstream holds the controller in place.
// Reset (rst, synchronous) clears the sequence register, match count and
// finished flag. After a stop or end marker every request is taken and dropped.

module stop_sequence_stream_filter
  import ssf_pkg::*;
#(
  parameter int SEQ_LEN = SEQ_LEN_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  ssf_in_if.sink                upstream,
  ssf_out_if.source             downstream,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire [APB_ADDR_W-1:0]  paddr,
  input  wire [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  ctrl_cmd_t            cmd;
  dp_status_t           status;
  logic                 cfg_we;
  logic                 reg_hit;
  logic [SEQ_REG_W-1:0] stop_seq;
  logic                 in_ready;

  // one 64-bit register slot; bit 3 of the byte address picks the slot
  assign reg_hit = (paddr[3] == REG_STOP_SEQ);
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? {{(APB_DATA_W - SEQ_REG_W){1'b0}}, stop_seq} : '0;

  assign upstream.ready = in_ready;

  ssf_ctrl #(
    .SEQ_LEN (SEQ_LEN)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (upstream.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ssf_dp #(
    .SEQ_LEN (SEQ_LEN)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (pwdata[SEQ_REG_W-1:0]),
    .stop_seq   (stop_seq),
    .in_command (upstream.command),
    .in_byte    (upstream.in_byte),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (downstream.valid),
    .out_ready  (downstream.ready),
    .out_kind   (downstream.out_kind),
    .out_byte   (downstream.out_byte),
    .out_last   (downstream.out_last)
  );

endmodule

`default_nettype wire

// File: sv/ssf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ssf_ctrl
  import ssf_pkg::*;
#(
  parameter int SEQ_LEN = SEQ_LEN_DEF
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_EVAL    = 4'b0010,
    ST_RELEASE = 4'b0100,
    ST_TAIL    = 4'b1000
  } state_t;

  // what follows the released prefix
  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_DATA = 2'd1,
    TAIL_STOP = 2'd2,
    TAIL_END  = 2'd3
  } tail_t;

  state_t state, state_next;
  tail_t  tail, tail_next;
  tail_t  byte_tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tail  <= TAIL_NONE;
    end else begin
      state <= state_next;
      tail  <= tail_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  // outcome of the current byte after any prefix release
  always_comb begin
    if (!status.first_hit) begin
      byte_tail = TAIL_DATA;
    end else if (SEQ_LEN <= 1) begin
      byte_tail = TAIL_STOP;
    end else begin
      byte_tail = TAIL_NONE;
    end
  end

  always_comb begin
    state_next       = state;
    tail_next        = tail;
    cmd              = '0;
    cmd.cnt_op       = CNT_KEEP;
    cmd.emit_kind    = KIND_DATA;
    case (state)
      ST_IDLE: begin
        if (in_valid && !status.finished) begin
          cmd.capture = 1'b1;
          state_next  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status.cmd_end) begin
          tail_next = TAIL_END;
          if (status.cnt_zero) begin
            state_next = ST_TAIL;
          end else begin
            cmd.rel_clear = 1'b1;
            state_next    = ST_RELEASE;
          end
        end else if (!status.cnt_zero && status.match_hit) begin
          if (status.cnt_top) begin
            cmd.cnt_op = CNT_CLEAR;
            tail_next  = TAIL_STOP;
            state_next = ST_TAIL;
          end else begin
            cmd.cnt_op = CNT_INC;
            state_next = ST_IDLE;
          end
        end else if (status.cnt_zero) begin
          tail_next = byte_tail;
          if (byte_tail == TAIL_NONE) begin
            cmd.cnt_op = CNT_ONE;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_TAIL;
          end
        end else begin
          tail_next     = byte_tail;
          cmd.rel_clear = 1'b1;
          state_next    = ST_RELEASE;
        end
      end
      ST_RELEASE: begin
        if (status.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_prefix = 1'b1;
          cmd.emit_kind   = KIND_DATA;
          cmd.emit_last   = status.rel_at_end && (tail == TAIL_NONE);
          cmd.rel_inc     = 1'b1;
          if (status.rel_at_end) begin
            if (tail == TAIL_NONE) begin
              cmd.cnt_op = CNT_ONE;
              state_next = ST_IDLE;
            end else begin
              cmd.cnt_op = CNT_CLEAR;
              state_next = ST_TAIL;
            end
          end
        end
      end
      ST_TAIL: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          case (tail)
            TAIL_STOP: begin
              cmd.emit_kind    = KIND_STOP;
              cmd.set_finished = 1'b1;
            end
            TAIL_END: begin
              cmd.emit_kind    = KIND_END;
              cmd.set_finished = 1'b1;
            end
            default: begin
              cmd.emit_kind = KIND_DATA;
            end
          endcase
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/ssf_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ssf_dp
  import ssf_pkg::*;
#(
  parameter int SEQ_LEN = SEQ_LEN_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire [SEQ_REG_W-1:0]  cfg_wdata,
  output logic [SEQ_REG_W-1:0] stop_seq,
  input  wire                  in_command,
  input  wire [7:0]            in_byte,
  input  wire ctrl_cmd_t       cmd,
  output dp_status_t           status,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_byte,
  output logic                 out_last
);

  localparam int CNT_W = (SEQ_LEN > 1) ? $clog2(SEQ_LEN) : 1;

  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] rel_idx;
  logic             finished;
  logic             item_cmd;
  logic [7:0]       item_byte;
  logic             out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC:   cnt_next = cnt + CNT_W'(1);
      CNT_CLEAR: cnt_next = '0;
      CNT_ONE:   cnt_next = CNT_W'(1);
      default:   cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_seq  <= '0;
      cnt       <= '0;
      rel_idx   <= '0;
      finished  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        stop_seq <= cfg_wdata;
      end
      cnt <= cnt_next;
      if (cmd.rel_clear) begin
        rel_idx <= '0;
      end else if (cmd.rel_inc) begin
        rel_idx <= rel_idx + CNT_W'(1);
      end
      if (cmd.set_finished) begin
        finished <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_cmd  <= in_command;
      item_byte <= in_byte;
    end
    if (cmd.emit) begin
      out_kind <= cmd.emit_kind;
      out_last <= cmd.emit_last;
      if (cmd.emit_kind != KIND_DATA) begin
        out_byte <= 8'd0;
      end else if (cmd.emit_prefix) begin
        out_byte <= seq_byte(stop_seq, 3'(rel_idx));
      end else begin
        out_byte <= item_byte;
      end
    end
  end

  always_comb begin
    status.finished   = finished;
    status.cmd_end    = (item_cmd == CMD_END);
    status.cnt_zero   = (cnt == '0);
    status.match_hit  = (item_byte == seq_byte(stop_seq, 3'(cnt)));
    status.cnt_top    = (cnt == CNT_W'(SEQ_LEN - 1));
    status.first_hit  = (item_byte == seq_byte(stop_seq, 3'd0));
    status.rel_at_end = (rel_idx == cnt - CNT_W'(1));
    status.out_free   = out_free;
  end

endmodule

`default_nettype wire
